// ----- src/lis_pkg.sv -----
// Shared constants and types for the longest increasing subsequence block.
`timescale 1ns / 1ps

package lis_pkg;

    localparam int MAX_ELEMENTS = 512;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int VAL_W        = 32;
    localparam int LEN_W        = 10;
    localparam int POS_W        = 9;

    typedef struct packed {
        logic                    go;
        logic                    commit;
        logic [IDX_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
    } scan_cmd_t;

    typedef struct packed {
        logic             done;
        logic             has_link;
        logic [CNT_W-1:0] len;
        logic [IDX_W-1:0] link;
    } scan_res_t;

endpackage

// ----- src/lis_engine.sv -----
// Element store and scan engine: walks earlier entries one read per cycle.
`timescale 1ns / 1ps

module lis_engine
(
    input  logic                clk,
    input  logic                rst_n,
    input  lis_pkg::scan_cmd_t  cmd,
    output lis_pkg::scan_res_t  res
);

    localparam int DATA_W = lis_pkg::VAL_W + lis_pkg::CNT_W;

    logic [DATA_W-1:0] mem [lis_pkg::MAX_ELEMENTS];
    logic [DATA_W-1:0] rd_data_reg;

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic                            cmp_valid_reg, cmp_valid_next;
    logic [lis_pkg::IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [lis_pkg::IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [lis_pkg::IDX_W-1:0]       pos_reg, pos_next;
    logic signed [lis_pkg::VAL_W-1:0] value_reg, value_next;
    logic [lis_pkg::CNT_W-1:0]       len_reg, len_next;
    logic [lis_pkg::IDX_W-1:0]       link_reg, link_next;
    logic                            has_link_reg, has_link_next;

    logic                            rd_en;
    logic signed [lis_pkg::VAL_W-1:0] rd_val;
    logic [lis_pkg::CNT_W-1:0]       rd_len;

    assign rd_val = $signed(rd_data_reg[DATA_W-1 -: lis_pkg::VAL_W]);
    assign rd_len = rd_data_reg[lis_pkg::CNT_W-1:0];
    assign rd_en  = busy_reg && (rd_idx_reg != pos_reg);

    always_comb
    begin
        busy_next      = busy_reg;
        done_next      = done_reg;
        cmp_valid_next = 1'b0;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        pos_next       = pos_reg;
        value_next     = value_reg;
        len_next       = len_reg;
        link_next      = link_reg;
        has_link_next  = has_link_reg;

        if (cmd.go)
        begin
            busy_next     = 1'b1;
            done_next     = 1'b0;
            rd_idx_next   = '0;
            pos_next      = cmd.pos;
            value_next    = cmd.value;
            len_next      = lis_pkg::CNT_W'(1);
            link_next     = '0;
            has_link_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (rd_en)
            begin
                rd_idx_next    = rd_idx_reg + 1'b1;
                cmp_valid_next = 1'b1;
                cmp_idx_next   = rd_idx_reg;
            end
            // strictly smaller value, strictly longer chain: earliest wins ties
            if (cmp_valid_reg && (rd_val < value_reg) && (rd_len >= len_reg))
            begin
                len_next      = rd_len + 1'b1;
                link_next     = cmp_idx_reg;
                has_link_next = 1'b1;
            end
            if (!rd_en && !cmp_valid_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            cmp_valid_reg <= 1'b0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            done_reg      <= done_next;
            cmp_valid_reg <= cmp_valid_next;
            rd_idx_reg    <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        pos_reg      <= pos_next;
        value_reg    <= value_next;
        len_reg      <= len_next;
        link_reg     <= link_next;
        has_link_reg <= has_link_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            mem[pos_reg] <= {value_reg, len_reg};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    assign res.done     = done_reg;
    assign res.has_link = has_link_reg;
    assign res.len      = len_reg;
    assign res.link     = link_reg;

endmodule

// ----- src/longest_increasing_subsequence.sv -----
// Top level: streaming longest strictly increasing subsequence, quadratic scan.
//
//  channel  | valid         | stall         | fields
//  ---------+---------------+---------------+---------------------------------------
//  item     | item_valid    | item_stall    | value, starts_sequence
//  result   | result_valid  | result_stall  | chain_length, predecessor, position,
//           |               |               | best_length, best_position, overflow
//
// An element stored at index p needs one store read per earlier element on the single
// read port, plus issue, last compare and write-back.
// A refused element skips the scan. One element is in work at a time.
// Reset clears the count and best registers; the store needs no clearing.
// A new item is taken while the previous result waits; a held result stalls write-back.
`timescale 1ns / 1ps

module longest_increasing_subsequence
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic signed [lis_pkg::VAL_W-1:0]    value,
    input  logic                                starts_sequence,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [lis_pkg::LEN_W-1:0]           chain_length,
    output logic signed [lis_pkg::LEN_W-1:0]    predecessor,
    output logic [lis_pkg::POS_W-1:0]           position,
    output logic [lis_pkg::LEN_W-1:0]           best_length,
    output logic [lis_pkg::POS_W-1:0]           best_position,
    output logic                                overflow
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [lis_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [lis_pkg::CNT_W-1:0]   max_len_reg, max_len_next;
    logic [lis_pkg::IDX_W-1:0]   max_end_reg, max_end_next;
    logic                        ovf_reg, ovf_next;
    logic [lis_pkg::IDX_W-1:0]   pos_reg, pos_next;

    logic                              out_valid_reg, out_valid_next;
    logic [lis_pkg::LEN_W-1:0]         chain_length_reg, chain_length_next;
    logic signed [lis_pkg::LEN_W-1:0]  predecessor_reg, predecessor_next;
    logic [lis_pkg::POS_W-1:0]         position_reg, position_next;
    logic [lis_pkg::LEN_W-1:0]         best_length_reg, best_length_next;
    logic [lis_pkg::POS_W-1:0]         best_position_reg, best_position_next;
    logic                              overflow_reg, overflow_next;

    logic                        accept;
    logic                        out_free;
    logic [lis_pkg::CNT_W-1:0]   count_eff;
    logic                        full;
    lis_pkg::scan_cmd_t          cmd;
    lis_pkg::scan_res_t          res;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign out_free   = !out_valid_reg || !result_stall;
    assign count_eff  = starts_sequence ? '0 : count_reg;
    assign full       = (count_eff >= lis_pkg::CNT_W'(lis_pkg::MAX_ELEMENTS));

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        max_len_next       = max_len_reg;
        max_end_next       = max_end_reg;
        ovf_next           = ovf_reg;
        pos_next           = pos_reg;
        out_valid_next     = out_valid_reg && result_stall;
        chain_length_next  = chain_length_reg;
        predecessor_next   = predecessor_reg;
        position_next      = position_reg;
        best_length_next   = best_length_reg;
        best_position_next = best_position_reg;
        overflow_next      = overflow_reg;
        cmd.go             = 1'b0;
        cmd.commit         = 1'b0;
        cmd.pos            = count_eff[lis_pkg::IDX_W-1:0];
        cmd.value          = value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (starts_sequence)
                    begin
                        count_next   = '0;
                        max_len_next = '0;
                        max_end_next = '0;
                    end
                    pos_next = count_eff[lis_pkg::IDX_W-1:0];
                    ovf_next = full;
                    if (full)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.go     = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (res.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (ovf_reg)
                    begin
                        chain_length_next  = '0;
                        predecessor_next   = '1;
                        position_next      = '0;
                        best_length_next   = lis_pkg::LEN_W'(max_len_reg);
                        best_position_next = lis_pkg::POS_W'(max_end_reg);
                        overflow_next      = 1'b1;
                    end
                    else
                    begin
                        cmd.commit = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (res.len >= max_len_reg)
                        begin
                            max_len_next = res.len;
                            max_end_next = pos_reg;
                        end
                        chain_length_next  = lis_pkg::LEN_W'(res.len);
                        predecessor_next   = res.has_link ?
                                             $signed(lis_pkg::LEN_W'(res.link)) : '1;
                        position_next      = lis_pkg::POS_W'(pos_reg);
                        best_length_next   = lis_pkg::LEN_W'(max_len_next);
                        best_position_next = lis_pkg::POS_W'(max_end_next);
                        overflow_next      = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            max_len_reg   <= '0;
            max_end_reg   <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            max_len_reg   <= max_len_next;
            max_end_reg   <= max_end_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg           <= pos_next;
        chain_length_reg  <= chain_length_next;
        predecessor_reg   <= predecessor_next;
        position_reg      <= position_next;
        best_length_reg   <= best_length_next;
        best_position_reg <= best_position_next;
        overflow_reg      <= overflow_next;
    end

    lis_engine u_engine
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    assign result_valid  = out_valid_reg;
    assign chain_length  = chain_length_reg;
    assign predecessor   = predecessor_reg;
    assign position      = position_reg;
    assign best_length   = best_length_reg;
    assign best_position = best_position_reg;
    assign overflow      = overflow_reg;

endmodule

// ----- tb/lis_checker.sv -----
// Checker for the longest increasing subsequence block: predicts each result and compares.
`timescale 1ns / 1ps

module lis_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    input  logic                             item_stall,
    input  logic signed [lis_pkg::VAL_W-1:0] value,
    input  logic                             starts_sequence,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  logic [lis_pkg::LEN_W-1:0]        chain_length,
    input  logic signed [lis_pkg::LEN_W-1:0] predecessor,
    input  logic [lis_pkg::POS_W-1:0]        position,
    input  logic [lis_pkg::LEN_W-1:0]        best_length,
    input  logic [lis_pkg::POS_W-1:0]        best_position,
    input  logic                             overflow,
    output int                               errors,
    output int                               pending
);

    typedef struct packed {
        logic [lis_pkg::LEN_W-1:0] chain_length;
        logic [lis_pkg::LEN_W-1:0] predecessor;
        logic [lis_pkg::POS_W-1:0] position;
        logic [lis_pkg::LEN_W-1:0] best_length;
        logic [lis_pkg::POS_W-1:0] best_position;
        logic                      overflow;
    } lis_result_t;

    logic signed [lis_pkg::VAL_W-1:0] seq_vals [lis_pkg::MAX_ELEMENTS];
    int                               seq_lens [lis_pkg::MAX_ELEMENTS];
    int                               elem_cnt;
    int                               longest_len;
    int                               longest_end;
    lis_result_t                      expected_q [$];

    function automatic lis_result_t predict_chain(
        input logic signed [lis_pkg::VAL_W-1:0] v,
        input logic s);
        lis_result_t r;
        int          len;
        int          link;
        if (s)
        begin
            elem_cnt    = 0;
            longest_len = 0;
            longest_end = 0;
        end
        if (elem_cnt >= lis_pkg::MAX_ELEMENTS)
        begin
            r.chain_length  = '0;
            r.predecessor   = '1;
            r.position      = '0;
            r.best_length   = lis_pkg::LEN_W'(longest_len);
            r.best_position = lis_pkg::POS_W'(longest_end);
            r.overflow      = 1'b1;
            return r;
        end
        len  = 1;
        link = -1;
        // strict compare keeps the earliest predecessor on equal length
        for (int j = 0; j < elem_cnt; j++)
        begin
            if (seq_vals[j] < v && seq_lens[j] + 1 > len)
            begin
                len  = seq_lens[j] + 1;
                link = j;
            end
        end
        seq_vals[elem_cnt] = v;
        seq_lens[elem_cnt] = len;
        if (len >= longest_len)
        begin
            longest_len = len;
            longest_end = elem_cnt;
        end
        r.chain_length  = lis_pkg::LEN_W'(len);
        r.predecessor   = lis_pkg::LEN_W'(link);
        r.position      = lis_pkg::POS_W'(elem_cnt);
        r.best_length   = lis_pkg::LEN_W'(longest_len);
        r.best_position = lis_pkg::POS_W'(longest_end);
        r.overflow      = 1'b0;
        elem_cnt++;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lis_result_t got;
        lis_result_t want;
        if (!rst_n)
        begin
            elem_cnt    = 0;
            longest_len = 0;
            longest_end = 0;
            expected_q.delete();
            errors      = 0;
            pending     = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                expected_q.push_back(predict_chain(value, starts_sequence));
            if (result_valid && !result_stall)
            begin
                got = '{chain_length, predecessor, position, best_length, best_position,
                        overflow};
                if (expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no item pending: len=%0d pred=%0d pos=%0d",
                             $time, chain_length, predecessor, position);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display({"%0t: mismatch: expected len=%0d pred=%0d pos=%0d ",
                                  "best=%0d@%0d ovf=%0b, actual len=%0d pred=%0d pos=%0d ",
                                  "best=%0d@%0d ovf=%0b"},
                                 $time, want.chain_length, $signed(want.predecessor),
                                 want.position, want.best_length, want.best_position,
                                 want.overflow, got.chain_length, $signed(got.predecessor),
                                 got.position, got.best_length, got.best_position,
                                 got.overflow);
                    end
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

// ----- tb/longest_increasing_subsequence_tb.sv -----
// Testbench top for the longest increasing subsequence block: stimulus, idling and verdict.
`timescale 1ns / 1ps

module longest_increasing_subsequence_tb;

    logic                             clk             = 1'b0;
    logic                             rst_n           = 1'b0;
    logic                             item_valid      = 1'b0;
    logic                             item_stall;
    logic signed [lis_pkg::VAL_W-1:0] value           = '0;
    logic                             starts_sequence = 1'b0;
    logic                             result_valid;
    logic                             result_stall    = 1'b0;
    logic [lis_pkg::LEN_W-1:0]        chain_length;
    logic signed [lis_pkg::LEN_W-1:0] predecessor;
    logic [lis_pkg::POS_W-1:0]        position;
    logic [lis_pkg::LEN_W-1:0]        best_length;
    logic [lis_pkg::POS_W-1:0]        best_position;
    logic                             overflow;
    int                               errors;
    int                               pending;
    int                               tx_idle         = 0;
    int                               rx_idle         = 0;

    longest_increasing_subsequence u_top (.*);

    lis_checker u_checker (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        result_stall <= (rx_idle > 0) && ($urandom_range(0, 99) < rx_idle);

    task automatic send_item(input logic signed [lis_pkg::VAL_W-1:0] v, input logic s);
        while (tx_idle > 0 && $urandom_range(0, 99) < tx_idle)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid      <= 1'b1;
        value           <= v;
        starts_sequence <= s;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic set_idling(input int tx, input int rx);
        @(posedge clk);
        tx_idle = tx;
        rx_idle = rx;
        @(negedge clk);
    endtask

    function automatic logic signed [lis_pkg::VAL_W-1:0] pick_value(input int kind,
                                                                    input int k);
        logic signed [lis_pkg::VAL_W-1:0] v;
        case (kind)
            0: v = int'($urandom_range(0, 12)) - 6;
            1: v = $urandom;
            2: v = k * 100 + int'($urandom_range(0, 300)) - 150;
            default:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = -1;
                    3: v = 0;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic run_short_seqs(input int n_items);
        int   sent;
        int   len;
        int   kind;
        logic s;
        sent = 0;
        while (sent < n_items)
        begin
            len  = $urandom_range(1, 40);
            kind = $urandom_range(0, 3);
            for (int k = 0; k < len && sent < n_items; k++)
            begin
                // mostly clean sequences, with the odd continuation or early restart
                if (k == 0)
                    s = ($urandom_range(0, 9) != 0);
                else
                    s = ($urandom_range(0, 49) == 0);
                send_item(pick_value(kind, k), s);
                sent++;
            end
        end
    endtask

    task automatic run_full_store();
        longint cur;
        cur = -64'sd2147483648 + $urandom_range(0, 1000);
        send_item(cur[lis_pkg::VAL_W-1:0], 1'b1);
        for (int i = 1; i < lis_pkg::MAX_ELEMENTS; i++)
        begin
            cur = cur + $urandom_range(1, 8000000);
            send_item(cur[lis_pkg::VAL_W-1:0], 1'b0);
        end
        // store full: refused items
        repeat (6)
            send_item($urandom, 1'b0);
        // restart on a full store
        send_item($urandom, 1'b1);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(5, 1'b0);
        send_item(3, 1'b0);
        send_item(4, 1'b0);
        send_item(1, 1'b0);
        send_item(2, 1'b0);
        send_item(5, 1'b0);
        send_item(5, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(32'sh7fff_ffff, 1'b1);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(-1, 1'b0);
        send_item(0, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(-1, 1'b0);
        send_item(32'sh7fff_fffe, 1'b0);
        drain_results();

        set_idling(33, 48);
        run_short_seqs(330);
        drain_results();

        set_idling(48, 33);
        run_short_seqs(330);
        drain_results();

        set_idling(0, 0);
        run_full_store();
        run_short_seqs(10);
        drain_results();

        repeat (20) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("longest_increasing_subsequence_tb: done, clean");
        else
            $display("longest_increasing_subsequence_tb: done, errors");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("longest_increasing_subsequence_tb: done, errors");
        $finish;
    end

endmodule
